### hdl/sprc_pkg.sv
// ---------------------------------------------------------------------------
// sprc_pkg: shared types and constants
// Types, register codes and reset values for the sound peak rhythm classifier.
// ---------------------------------------------------------------------------
package sprc_pkg;

  localparam int PEAK_SLOTS_DEF      = 20;
  localparam int MUSIC_MAX_PEAKS_DEF = 18;
  localparam int MIN_INTERVALS_DEF   = 6;

  localparam logic [15:0] PEAK_WIN_RST  = 16'd1500;
  localparam logic [15:0] QUIET_WIN_RST = 16'd2500;
  localparam logic [15:0] COOLOFF_RST   = 16'd3000;
  localparam logic [31:0] VAR_LIM_RST   = 32'd12000;
  localparam logic [5:0]  NOISE_MIN_RST = 6'd10;
  localparam logic [5:0]  TALK_MIN_RST  = 6'd3;
  localparam logic [5:0]  TALK_MAX_RST  = 6'd14;
  localparam logic [5:0]  MUSIC_MIN_RST = 6'd8;
  localparam logic [31:0] MUSIC_SEEN_RST = 32'd4294964294;

  typedef enum logic [2:0] {
    REG_PEAK_WIN  = 3'd0,
    REG_QUIET_WIN = 3'd1,
    REG_COOLOFF   = 3'd2,
    REG_VAR_LIM   = 3'd3,
    REG_NOISE_MIN = 3'd4,
    REG_TALK_MIN  = 3'd5,
    REG_TALK_MAX  = 3'd6,
    REG_MUSIC_MIN = 3'd7
  } sprc_reg_t;

  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_ZERO = 2'd1,
    RD_LAST = 2'd2
  } sprc_rdsrc_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DROP_RD, S_DROP_CHK, S_DROP_DONE, S_EVAL, S_VFIRST, S_VLAST,
    S_VMEAN, S_VB0, S_VB_RD, S_VB_DAT, S_VB_SQ, S_VVAR, S_FINISH
  } sprc_state_t;

  typedef struct packed {
    logic        peak;
    logic        tick;
    logic        rd_en;
    sprc_rdsrc_t rd_src;
    logic        drop_chk;
    logic        drop_done;
    logic        eval;
    logic        prev_ld;
    logic        div_mean;
    logic        mean_ld;
    logic        pass_init;
    logic        diff_ld;
    logic        acc_ld;
    logic        div_var;
    logic        var_ld;
    logic        emit;
  } sprc_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic need_var;
    logic div_done;
  } sprc_stat_t;

endpackage

### hdl/sound_peak_rhythm_classifier.sv
// ---------------------------------------------------------------------------
// sound_peak_rhythm_classifier: sound peak rhythm classifier
// Classifies recent sound peaks as talking, noise, music or quiet.
// ---------------------------------------------------------------------------
// Usage: an input item with in_cmd low records a peak at in_time_ms; it gives
// no result. An item with in_cmd high is a tick: it drops stored peaks older
// than the peak window, classifies the rest and gives one result item with the
// four flags and three start pulses.
// A tick reads each stored peak in the discard pass. When spacing statistics
// are needed, it adds two divisions (mean and variance, one quotient bit per
// cycle) and a pass over the remaining intervals.
// The single read port of the peak store and the serial divider set the
// length of a tick.
// in_ready is high while the controller is idle; a peak item is taken even
// while a result waits in the output register. A tick that finishes while
// the receiver stalls holds in its last step until the result is taken.
// Configuration writes are taken in any cycle and belong in idle time.
// After reset the store is empty, thresholds hold their defaults and no
// result is pending.
// ---------------------------------------------------------------------------
module sound_peak_rhythm_classifier #(
  parameter int PEAK_SLOTS      = sprc_pkg::PEAK_SLOTS_DEF,
  parameter int MUSIC_MAX_PEAKS = sprc_pkg::MUSIC_MAX_PEAKS_DEF,
  parameter int MIN_INTERVALS   = sprc_pkg::MIN_INTERVALS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_talking,
  output logic        out_noise,
  output logic        out_music,
  output logic        out_quiet,
  output logic        out_talking_start,
  output logic        out_noise_start,
  output logic        out_music_start,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sprc_pkg::*;

  localparam int AW = $clog2(PEAK_SLOTS);
  localparam int CW = $clog2(PEAK_SLOTS + 1);

  sprc_cmd_t  cmd;
  sprc_stat_t stat;

  assign cfg_ready = 1'b1;

  sprc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sprc_datapath #(
    .PEAK_SLOTS      (PEAK_SLOTS),
    .MUSIC_MAX_PEAKS (MUSIC_MAX_PEAKS),
    .MIN_INTERVALS   (MIN_INTERVALS),
    .AW              (AW),
    .CW              (CW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_time_ms        (in_time_ms),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_talking       (out_talking),
    .out_noise         (out_noise),
    .out_music         (out_music),
    .out_quiet         (out_quiet),
    .out_talking_start (out_talking_start),
    .out_noise_start   (out_noise_start),
    .out_music_start   (out_music_start)
  );

endmodule

### hdl/sprc_ram.sv
// ---------------------------------------------------------------------------
// sprc_ram: generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sprc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/sprc_div.sv
// ---------------------------------------------------------------------------
// sprc_div: iterative divider
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// ---------------------------------------------------------------------------
module sprc_div #(
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [31:0]   quotient
);

  logic [31:0]   quot_r, quot_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quot_r[31]};
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt  = DW'(trial - {1'b0, dvs_r});
        quot_nxt = {quot_r[30:0], 1'b1};
      end else begin
        rem_nxt  = trial[DW-1:0];
        quot_nxt = {quot_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

### hdl/sprc_datapath.sv
// ---------------------------------------------------------------------------
// sprc_datapath: peak store and classification datapath
// Peak time ring, registers, interval statistics and result flags.
// ---------------------------------------------------------------------------
module sprc_datapath #(
  parameter int PEAK_SLOTS      = 20,
  parameter int MUSIC_MAX_PEAKS = 18,
  parameter int MIN_INTERVALS   = 6,
  parameter int AW              = $clog2(PEAK_SLOTS),
  parameter int CW              = $clog2(PEAK_SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sprc_pkg::sprc_cmd_t  cmd,
  output sprc_pkg::sprc_stat_t stat,
  input  logic [31:0]          in_time_ms,
  input  logic                 cfg_wr,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_talking,
  output logic                 out_noise,
  output logic                 out_music,
  output logic                 out_quiet,
  output logic                 out_talking_start,
  output logic                 out_noise_start,
  output logic                 out_music_start
);
  import sprc_pkg::*;

  logic [15:0] peak_win_r, quiet_win_r, cooloff_r;
  logic [31:0] var_lim_r;
  logic [5:0]  noise_min_r, talk_min_r, talk_max_r, music_min_r;

  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r, idx_r, kept_r;
  logic [31:0]   last_peak_r, music_seen_r, now_r;
  logic [31:0]   prev_r, mean_r, diff_r, acc_r;
  logic          var_hit_r;
  logic          flag_talk_r, flag_noise_r, flag_music_r;
  logic          o_talk_r, o_noise_r, o_music_r, o_quiet_r;
  logic          o_talk_st_r, o_noise_st_r, o_music_st_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic          keep, noise_c, need_var_c, talk_c, music_c;
  logic [CW-1:0] nint;
  logic          div_start, div_done;
  logic [31:0]   div_q, div_a;
  logic [63:0]   sq;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] j);
    logic [AW:0] s;
    s = {1'b0, head} + (AW+1)'(j);
    if (s >= (AW+1)'(PEAK_SLOTS)) begin
      s = s - (AW+1)'(PEAK_SLOTS);
    end
    return s[AW-1:0];
  endfunction

  assign nint = count_r - CW'(1);
  assign keep = (now_r - rdata) <= {16'b0, peak_win_r};

  assign noise_c    = 32'(count_r) >= 32'(noise_min_r);
  assign need_var_c = !noise_c && (32'(count_r) >= 32'(music_min_r)) &&
                      (32'(count_r) <= 32'(MUSIC_MAX_PEAKS)) &&
                      (32'(count_r) >= 32'(MIN_INTERVALS + 1)) && (32'(count_r) >= 32'd2);
  assign music_c    = var_hit_r || ((now_r - music_seen_r) < {16'b0, cooloff_r});
  assign talk_c     = !noise_c && !music_c && (32'(count_r) >= 32'(talk_min_r)) &&
                      (32'(count_r) <= 32'(talk_max_r));

  assign stat.idx_end  = idx_r == count_r;
  assign stat.need_var = need_var_c;
  assign stat.div_done = div_done;

  always_comb begin
    we    = 1'b0;
    waddr = phys(head_r, kept_r);
    wdata = rdata;
    if (cmd.peak) begin
      we    = 1'b1;
      wdata = in_time_ms;
      if (count_r == CW'(PEAK_SLOTS)) begin
        waddr = head_r;
      end else begin
        waddr = phys(head_r, count_r);
      end
    end else if (cmd.drop_chk) begin
      we = keep;
    end
  end

  always_comb begin
    case (cmd.rd_src)
      RD_ZERO: raddr = head_r;
      RD_LAST: raddr = phys(head_r, nint);
      default: raddr = phys(head_r, idx_r);
    endcase
  end

  sprc_ram #(.WIDTH(32), .DEPTH(PEAK_SLOTS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign div_start = cmd.div_mean || cmd.div_var;
  assign div_a     = cmd.div_mean ? (rdata - prev_r) : acc_r;

  sprc_div #(.DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (nint),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sq = diff_r * diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_win_r   <= PEAK_WIN_RST;
      quiet_win_r  <= QUIET_WIN_RST;
      cooloff_r    <= COOLOFF_RST;
      var_lim_r    <= VAR_LIM_RST;
      noise_min_r  <= NOISE_MIN_RST;
      talk_min_r   <= TALK_MIN_RST;
      talk_max_r   <= TALK_MAX_RST;
      music_min_r  <= MUSIC_MIN_RST;
      head_r       <= '0;
      count_r      <= '0;
      last_peak_r  <= '0;
      music_seen_r <= MUSIC_SEEN_RST;
      flag_talk_r  <= 1'b0;
      flag_noise_r <= 1'b0;
      flag_music_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_PEAK_WIN:  peak_win_r  <= cfg_data[15:0];
          REG_QUIET_WIN: quiet_win_r <= cfg_data[15:0];
          REG_COOLOFF:   cooloff_r   <= cfg_data[15:0];
          REG_VAR_LIM:   var_lim_r   <= cfg_data;
          REG_NOISE_MIN: noise_min_r <= cfg_data[5:0];
          REG_TALK_MIN:  talk_min_r  <= cfg_data[5:0];
          REG_TALK_MAX:  talk_max_r  <= cfg_data[5:0];
          REG_MUSIC_MIN: music_min_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (cmd.peak) begin
        last_peak_r <= in_time_ms;
        if (count_r == CW'(PEAK_SLOTS)) begin
          head_r <= phys(head_r, CW'(1));
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.drop_done) begin
        count_r <= kept_r;
      end
      if (cmd.emit) begin
        flag_talk_r  <= talk_c;
        flag_noise_r <= noise_c;
        flag_music_r <= music_c;
        if (var_hit_r) begin
          music_seen_r <= now_r;
        end
      end
    end
    if (cmd.tick) begin
      now_r  <= in_time_ms;
      idx_r  <= '0;
      kept_r <= '0;
    end
    if (cmd.drop_chk) begin
      idx_r <= idx_r + CW'(1);
      if (keep) begin
        kept_r <= kept_r + CW'(1);
      end
    end
    if (cmd.eval) begin
      var_hit_r <= 1'b0;
    end
    if (cmd.prev_ld) begin
      prev_r <= rdata;
    end
    if (cmd.mean_ld) begin
      mean_r <= div_q;
    end
    if (cmd.pass_init) begin
      idx_r <= CW'(1);
      acc_r <= '0;
    end
    if (cmd.diff_ld) begin
      diff_r <= rdata - prev_r - mean_r;
      prev_r <= rdata;
      idx_r  <= idx_r + CW'(1);
    end
    if (cmd.acc_ld) begin
      acc_r <= acc_r + sq[31:0];
    end
    if (cmd.var_ld) begin
      var_hit_r <= div_q < var_lim_r;
    end
    if (cmd.emit) begin
      o_talk_r     <= talk_c;
      o_noise_r    <= noise_c;
      o_music_r    <= music_c;
      o_quiet_r    <= (now_r - last_peak_r) >= {16'b0, quiet_win_r};
      o_talk_st_r  <= talk_c && !flag_talk_r;
      o_noise_st_r <= noise_c && !flag_noise_r;
      o_music_st_r <= music_c && !flag_music_r;
    end
  end

  assign out_talking       = o_talk_r;
  assign out_noise         = o_noise_r;
  assign out_music         = o_music_r;
  assign out_quiet         = o_quiet_r;
  assign out_talking_start = o_talk_st_r;
  assign out_noise_start   = o_noise_st_r;
  assign out_music_start   = o_music_st_r;

endmodule

### hdl/sprc_ctrl.sv
// ---------------------------------------------------------------------------
// sprc_ctrl: sequencing controller
// Steps the datapath through the peak discard, statistics and result phases.
// ---------------------------------------------------------------------------
module sprc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sprc_pkg::sprc_cmd_t  cmd,
  input  sprc_pkg::sprc_stat_t stat
);
  import sprc_pkg::*;

  sprc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept, out_busy;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign out_busy = out_valid_r && !out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (accept && in_cmd) state_nxt = S_DROP_RD;
      S_DROP_RD:   state_nxt = stat.idx_end ? S_DROP_DONE : S_DROP_CHK;
      S_DROP_CHK:  state_nxt = S_DROP_RD;
      S_DROP_DONE: state_nxt = S_EVAL;
      S_EVAL:      state_nxt = stat.need_var ? S_VFIRST : S_FINISH;
      S_VFIRST:    state_nxt = S_VLAST;
      S_VLAST:     state_nxt = S_VMEAN;
      S_VMEAN:     if (stat.div_done) state_nxt = S_VB0;
      S_VB0:       state_nxt = S_VB_RD;
      S_VB_RD:     state_nxt = stat.idx_end ? S_VVAR : S_VB_DAT;
      S_VB_DAT:    state_nxt = S_VB_SQ;
      S_VB_SQ:     state_nxt = S_VB_RD;
      S_VVAR:      if (stat.div_done) state_nxt = S_FINISH;
      S_FINISH:    if (!out_busy) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.rd_src    = RD_IDX;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        cmd.peak = accept && !in_cmd;
        cmd.tick = accept && in_cmd;
      end
      S_DROP_RD:   cmd.rd_en = !stat.idx_end;
      S_DROP_CHK:  cmd.drop_chk = 1'b1;
      S_DROP_DONE: cmd.drop_done = 1'b1;
      S_EVAL: begin
        cmd.eval   = 1'b1;
        cmd.rd_en  = stat.need_var;
        cmd.rd_src = RD_ZERO;
      end
      S_VFIRST: begin
        cmd.prev_ld = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_src  = RD_LAST;
      end
      S_VLAST: cmd.div_mean = 1'b1;
      S_VMEAN: begin
        cmd.mean_ld = stat.div_done;
        cmd.rd_en   = stat.div_done;
        cmd.rd_src  = RD_ZERO;
      end
      S_VB0: begin
        cmd.prev_ld   = 1'b1;
        cmd.pass_init = 1'b1;
      end
      S_VB_RD: begin
        cmd.div_var = stat.idx_end;
        cmd.rd_en   = !stat.idx_end;
      end
      S_VB_DAT: cmd.diff_ld = 1'b1;
      S_VB_SQ:  cmd.acc_ld = 1'b1;
      S_VVAR:   cmd.var_ld = stat.div_done;
      S_FINISH: begin
        cmd.emit = !out_busy;
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/sprc_checker.sv
// ---------------------------------------------------------------------------
// sprc_checker: port checks
// Checks on the result channel of the classifier, bound to the top level.
// ---------------------------------------------------------------------------
module sprc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_talking,
  input logic out_noise,
  input logic out_music,
  input logic out_talking_start,
  input logic out_noise_start,
  input logic out_music_start
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_talking) && $stable(out_noise)
      && $stable(out_music))
    else $error("result changed while stalled");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_talking_start || out_talking) && (!out_noise_start || out_noise)
      && (!out_music_start || out_music))
    else $error("start pulse without its flag");

  a_noise_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_noise |-> !out_talking)
    else $error("talking together with noise");

  a_music_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_music |-> !out_talking)
    else $error("talking together with music");

endmodule

bind sound_peak_rhythm_classifier sprc_checker u_sprc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_talking       (out_talking),
  .out_noise         (out_noise),
  .out_music         (out_music),
  .out_talking_start (out_talking_start),
  .out_noise_start   (out_noise_start),
  .out_music_start   (out_music_start)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: sound peak rhythm classifier testbench
// Drives peak and tick items through the valid/ready input channel, predicts
// each tick's flags and start pulses in a behavioral model of the classifier
// and compares every result item against the oldest prediction. Thresholds
// are reprogrammed between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_top;
  import sprc_pkg::*;

  localparam int SLOTS = PEAK_SLOTS_DEF;
  localparam int MUSIC_MAX = MUSIC_MAX_PEAKS_DEF;
  localparam int MIN_IVL = MIN_INTERVALS_DEF;
  localparam logic CMD_PEAK = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic talking, noise, music, quiet, talking_start, noise_start, music_start;
  } flags_t;

  typedef struct {
    logic cmd;
    logic [31:0] t;
    logic chk;
    flags_t fl;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_cmd = 1'b0;
  logic [31:0] in_time_ms = '0;
  logic in_ready;
  logic out_valid, out_ready = 1'b0;
  logic out_talking, out_noise, out_music, out_quiet;
  logic out_talking_start, out_noise_start, out_music_start;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  sound_peak_rhythm_classifier dut (.*);

  // Predictor state.
  logic [15:0] win_ms, quiet_ms, cool_ms;
  logic [31:0] var_lim;
  logic [5:0] noise_min, talk_min, talk_max, music_min;
  logic [31:0] peak_ring[SLOTS];
  int unsigned n_peaks;
  logic [31:0] last_peak, music_at;
  logic was_talking, was_noise, was_music;

  flags_t flags_due[$];
  flags_t typed_due[$];
  logic typed_has[$];
  int errors = 0;
  bit stall_rx = 0, no_idle = 0;

  task automatic report(input string what);
    $display("ERROR %0t: %s", $time, what);
    errors++;
  endtask

  task automatic reset_model();
    win_ms = PEAK_WIN_RST; quiet_ms = QUIET_WIN_RST; cool_ms = COOLOFF_RST;
    var_lim = VAR_LIM_RST; noise_min = NOISE_MIN_RST; talk_min = TALK_MIN_RST;
    talk_max = TALK_MAX_RST; music_min = MUSIC_MIN_RST;
    n_peaks = 0; last_peak = '0; music_at = MUSIC_SEEN_RST;
    was_talking = 0; was_noise = 0; was_music = 0;
  endtask

  function automatic logic [31:0] spacing_var();
    logic [31:0] sum, mean, acc, d, sq;
    int unsigned n;
    if (n_peaks < MIN_IVL + 1 || n_peaks < 2) return 32'hFFFF_FFFF;
    n = n_peaks - 1;
    sum = '0; acc = '0;
    for (int i = 0; i < n; i++) sum += peak_ring[i+1] - peak_ring[i];
    mean = sum / n;
    for (int i = 0; i < n; i++) begin
      d = (peak_ring[i+1] - peak_ring[i]) - mean;
      sq = d * d;
      acc += sq;
    end
    return acc / n;
  endfunction

  function automatic flags_t classify(input logic [31:0] now);
    flags_t f;
    int unsigned kept = 0;
    logic nz, mu = 0, tk, qt;
    for (int i = 0; i < n_peaks; i++)
      if (32'(now - peak_ring[i]) <= 32'(win_ms)) begin
        peak_ring[kept] = peak_ring[i];
        kept++;
      end
    n_peaks = kept;
    qt = 32'(now - last_peak) >= 32'(quiet_ms);
    nz = n_peaks >= noise_min;
    if (!nz && n_peaks >= music_min && n_peaks <= MUSIC_MAX)
      if (spacing_var() < var_lim) begin
        mu = 1;
        music_at = now;
      end
    if (!mu && 32'(now - music_at) < 32'(cool_ms)) mu = 1;
    tk = !nz && !mu && n_peaks >= talk_min && n_peaks <= talk_max;
    f = '{tk, nz, mu, qt, tk && !was_talking, nz && !was_noise, mu && !was_music};
    was_talking = tk; was_noise = nz; was_music = mu;
    return f;
  endfunction

  task automatic add_peak(input logic [31:0] now);
    last_peak = now;
    if (n_peaks < SLOTS) begin
      peak_ring[n_peaks] = now;
      n_peaks++;
    end else begin
      for (int i = 1; i < SLOTS; i++) peak_ring[i-1] = peak_ring[i];
      peak_ring[SLOTS-1] = now;
    end
  endtask

  // Valid stays high from one item to the next unless an idle gap is taken;
  // the caller drops it after the last item of a sequence.
  task automatic send(input logic cmd, input logic [31:0] t, input logic chk,
                      input flags_t fl);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_cmd <= cmd; in_time_ms <= t;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_PEAK) add_peak(t);
    else begin
      flags_due.push_back(classify(t));
      typed_due.push_back(fl);
      typed_has.push_back(chk);
    end
  endtask

  task automatic drain();
    while (flags_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input sprc_reg_t idx, input logic [31:0] v);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PEAK_WIN:  win_ms = v[15:0];
      REG_QUIET_WIN: quiet_ms = v[15:0];
      REG_COOLOFF:   cool_ms = v[15:0];
      REG_VAR_LIM:   var_lim = v;
      REG_NOISE_MIN: noise_min = v[5:0];
      REG_TALK_MIN:  talk_min = v[5:0];
      REG_TALK_MAX:  talk_max = v[5:0];
      REG_MUSIC_MIN: music_min = v[5:0];
      default: ;
    endcase
  endtask

  task automatic program_all(input logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(sprc_reg_t'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  // Random phase: mostly regular peak trains with jitter, ticks in between.
  task automatic random_phase(input int items, input logic [31:0] t0);
    logic [31:0] now = t0;
    int unsigned step, jit;
    step = $urandom_range(40, 400);
    jit = $urandom_range(0, 30);
    for (int k = 0; k < items; k++) begin
      int unsigned r = $urandom_range(99);
      if (r < 8) step = $urandom_range(1, 600);
      if (r < 3) send(CMD_PEAK, $urandom, 0, '0);
      else if (r < 5) send(CMD_TICK, $urandom, 0, '0);
      else if (r < 60) begin
        now += step + $urandom_range(0, jit);
        send(CMD_PEAK, now, 0, '0);
      end else begin
        now += $urandom_range(0, 3 * step);
        send(CMD_TICK, now, 0, '0);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      flags_t got, want;
      got = '{out_talking, out_noise, out_music, out_quiet,
              out_talking_start, out_noise_start, out_music_start};
      if (flags_due.size() == 0) report("result item with no tick pending");
      else begin
        want = flags_due.pop_front();
        if (typed_has.pop_front() && typed_due[0] != want)
          report($sformatf("table entry %b disagrees with model %b", typed_due[0], want));
        void'(typed_due.pop_front());
        if (got.talking != want.talking) report("talking mismatch");
        if (got.noise != want.noise) report("noise mismatch");
        if (got.music != want.music) report("music mismatch");
        if (got.quiet != want.quiet) report("quiet mismatch");
        if (got.talking_start != want.talking_start) report("talking_start mismatch");
        if (got.noise_start != want.noise_start) report("noise_start mismatch");
        if (got.music_start != want.music_start) report("music_start mismatch");
      end
    end
  end

  // Receiver.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_rx) out_ready <= 1'b0;
      else out_ready <= no_idle || ($urandom_range(99) >= 35);
    end
  end

  row_t dir[$];
  initial begin
    logic [31:0] cfgv[8];
    logic [31:0] t;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reset_model();

    // Directed: the first tick after reset shows no flag, then edge cases.
    dir.push_back('{CMD_TICK, 32'd0, 1, 7'b0000000});
    dir.push_back('{CMD_TICK, 32'd2500, 1, 7'b0001000});
    dir.push_back('{CMD_TICK, 32'hFFFF_FFFF, 1, 7'b0001000});
    for (int i = 0; i < 10; i++) dir.push_back('{CMD_PEAK, 32'd10000 + i * 100, 0, '0});
    dir.push_back('{CMD_TICK, 32'd10950, 0, '0});
    for (int i = 0; i < 10; i++) dir.push_back('{CMD_PEAK, 32'hFFFF_FF00 + i * 60, 0, '0});
    dir.push_back('{CMD_TICK, 32'd300, 0, '0});
    foreach (dir[i]) send(dir[i].cmd, dir[i].t, dir[i].chk, dir[i].fl);
    in_valid <= 1'b0;
    drain();

    random_phase(500, $urandom);
    drain();

    // Hold the receiver off while items keep coming.
    fork
      begin
        stall_rx = 1;
        repeat (3000) @(posedge clk);
        stall_rx = 0;
      end
      random_phase(60, 32'd5000);
    join
    drain();

    cfgv = '{32'd65535, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd32, 32'd0, 32'd32, 32'd0};
    program_all(cfgv);
    no_idle = 1;
    random_phase(300, $urandom);
    no_idle = 0;
    drain();

    cfgv = '{32'd1, 32'd65535, 32'd65535, 32'd0, 32'd0, 32'd32, 32'd0, 32'd32};
    program_all(cfgv);
    random_phase(150, $urandom);
    drain();

    cfgv = '{32'h5A5A_A5A5, 32'hFFFF_0FA0, 32'd800, 32'd60000,
             32'd19, 32'd2, 32'd20, 32'd7};
    program_all(cfgv);
    random_phase(600, $urandom);
    drain();

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
